### hw/rtl/rihe_pkg.sv
// Shared types, codes and constants of the ROM image Intel HEX encoder.
// No dependencies; every other RTL file but rihe_checker imports this package.
package rihe_pkg;

  // Largest record length the encoder supports (one item is at most 60 characters).
  localparam int unsigned RecCapMax = 24;
  // Width of a record length (0..RecCapMax).
  localparam int unsigned LenW      = 5;
  // Width of a byte index within one record line (0..RecCapMax+4).
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [16:0] AddrTop   = 17'h10000;
  localparam logic [7:0]  CharColon = 8'h3A;
  localparam logic [7:0]  CharNl    = 8'h0A;
  localparam logic [7:0]  TypeData  = 8'h00;
  localparam logic [7:0]  TypeEnd   = 8'h01;
  localparam logic [7:0]  TypeSeg   = 8'h02;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_SEAL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_LOAD_BASE  = 2'd0,
    REG_KILL_BELOW = 2'd1,
    REG_LOAD_LIMIT = 2'd2,
    REG_CKSUM_ADDR = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COLON,
    BK_HI,
    BK_LO,
    BK_NL
  } back_state_e;

  typedef enum logic [1:0] {
    PART_SEG,
    PART_REC,
    PART_CK,
    PART_END
  } part_e;

  typedef struct packed {
    logic [19:0] load_base;
    logic [15:0] kill_below;
    logic [16:0] load_limit;
    logic [15:0] cksum_addr;
  } cfg_t;

  // Work for the back end caused by one input item.
  typedef struct packed {
    logic            seg;          // segment record due
    logic [15:0]     seg_payload;
    logic            rec;          // data record from the record buffer
    logic [LenW-1:0] rec_len;
    logic [15:0]     rec_start;
    logic            rec_bank;
    logic            seal;         // checksum record, then end record
    logic [7:0]      ck_byte;
    logic [15:0]     ck_addr;
    logic            ovf_hdr;      // overflow flag on segment record characters
    logic            ovf_body;     // overflow flag on all other characters
  } desc_t;

  typedef struct packed {
    logic            en;
    logic            bank;
    logic [LenW-1:0] slot;
    logic [7:0]      data;
  } buf_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

### hw/rtl/rihe_ifs.sv
// Valid/ready channel interfaces of the ROM image Intel HEX encoder.
// Depends on rihe_pkg for the configuration port widths.
interface rihe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, opcode, data_byte, input ready);
  modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface rihe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_of_run;
  logic       overflow_flag;
  modport source (output valid, ascii_char, last_of_run, overflow_flag, input ready);
  modport sink   (input valid, ascii_char, last_of_run, overflow_flag, output ready);
endinterface

interface rihe_cfg_if import rihe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/rihe_desc_fifo.sv
// Two-entry queue of work descriptors between front and back end.
// Depends on rihe_pkg (desc_t).
module rihe_desc_fifo import rihe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t head_o
);

  localparam logic [1:0] Depth = 2'd2;

  desc_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == Depth);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

### hw/rtl/rihe_front.sv
// Front end: accepts input items, tracks addresses, fill and image sum,
// writes record bytes and queues work descriptors. Depends on rihe_pkg.
module rihe_front import rihe_pkg::*; #(
  parameter int unsigned RecCap = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic      fifo_full_i,
  output logic      push_o,
  output desc_t     push_desc_o,
  output buf_wr_t   buf_wr_o,
  input  bank_rel_t bank_rel_i
);

  logic [LenW-1:0] fill_q, fill_d;
  logic [15:0]     start_q, start_d;
  logic [16:0]     next_q, next_d;
  logic [7:0]      sum_q, sum_d;
  logic            hdr_q, hdr_d;
  logic            ovf_q, ovf_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  opcode_e         op;
  logic            accept;
  logic            close;
  logic [LenW-1:0] fill_cur;
  logic [15:0]     start_cur;

  assign op         = opcode_e'(opcode_i);
  // Hold off while the queue is full or the bank to fill is still being sent.
  assign in_ready_o = !fifo_full_i && !busy_q[bank_q];
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    fill_d    = fill_q;
    start_d   = start_q;
    next_d    = next_q;
    sum_d     = sum_q;
    hdr_d     = hdr_q;
    ovf_d     = ovf_q;
    bank_d    = bank_q;
    busy_d    = busy_q;
    close     = 1'b0;
    fill_cur  = fill_q;
    start_cur = start_q;
    buf_wr_o  = '0;
    push_o    = 1'b0;

    push_desc_o             = '0;
    push_desc_o.seg_payload = cfg_i.load_base[19:4];
    push_desc_o.rec_bank    = bank_q;
    push_desc_o.ck_byte     = ~sum_q + 8'd1;
    push_desc_o.ck_addr     = cfg_i.cksum_addr;
    push_desc_o.ovf_hdr     = ovf_q;
    push_desc_o.ovf_body    = ovf_q;

    if (bank_rel_i.en) begin
      busy_d[bank_rel_i.bank] = 1'b0;
    end

    if (accept && (op != OP_NONE)) begin
      push_desc_o.seg = !hdr_q;
      hdr_d           = 1'b1;

      unique case (op)
        OP_DATA: begin
          if (next_q[16]) begin
            // Past the 64K window: drop and flag.
            ovf_d                = 1'b1;
            push_desc_o.ovf_body = 1'b1;
            close                = 1'b1;
          end else if (next_q > cfg_i.load_limit) begin
            close  = 1'b1;
            next_d = next_q + 17'd1;
          end else begin
            if (fill_q == '0) begin
              start_d = next_q[15:0];
            end
            start_cur     = start_d;
            buf_wr_o.en   = 1'b1;
            buf_wr_o.bank = bank_q;
            buf_wr_o.slot = fill_q;
            buf_wr_o.data = data_byte_i;
            fill_cur      = fill_q + LenW'(1);
            sum_d         = sum_q + data_byte_i;
            next_d        = next_q + 17'd1;
            close         = (fill_cur >= LenW'(RecCap));
          end
        end
        OP_FLUSH: close = 1'b1;
        OP_SEAL: begin
          if (fill_q != '0) begin
            close = 1'b1;
          end else begin
            push_desc_o.seal = 1'b1;
            next_d           = '0;
            sum_d            = '0;
            start_d          = '0;
            hdr_d            = 1'b0;
            ovf_d            = 1'b0;
          end
        end
        default: ;
      endcase

      fill_d = fill_cur;
      if (close && (fill_cur != '0)) begin
        fill_d = '0;
        if (start_cur >= cfg_i.kill_below) begin
          push_desc_o.rec       = 1'b1;
          push_desc_o.rec_len   = fill_cur;
          push_desc_o.rec_start = start_cur;
          bank_d                = ~bank_q;
          busy_d[bank_q]        = 1'b1;
        end
      end

      push_o = push_desc_o.seg || push_desc_o.rec || push_desc_o.seal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      start_q <= '0;
      next_q  <= '0;
      sum_q   <= '0;
      hdr_q   <= 1'b0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      start_q <= start_d;
      next_q  <= next_d;
      sum_q   <= sum_d;
      hdr_q   <= hdr_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

### hw/rtl/rihe_back.sv
// Back end: walks queued descriptors, emits one HEX character per cycle while not
// stalled, via an output register; owns the two-bank record buffer. Uses rihe_pkg.
module rihe_back import rihe_pkg::*; #(
  parameter int unsigned RecCap = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  input  buf_wr_t    buf_wr_i,
  output bank_rel_t  bank_rel_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] ascii_char_o,
  output logic       last_of_run_o,
  output logic       overflow_flag_o
);

  localparam int unsigned SlotW = (RecCap > 1) ? $clog2(RecCap) : 1;

  back_state_e     state_q, state_d;
  part_e           part_q, part_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;
  logic            ovf_q, ovf_d;

  logic [7:0]      mem_q [2][RecCap];
  logic [7:0]      rd_q;
  logic [SlotW-1:0] rd_slot;
  logic [IdxW-1:0] data_idx;

  logic            adv;
  logic [LenW-1:0] len_v;
  logic [15:0]     addr_v;
  logic [7:0]      type_v;
  logic [7:0]      data_v;
  logic [7:0]      cur_byte;
  logic [IdxW-1:0] last_idx;
  logic            has_next;
  part_e           next_part;
  part_e           start_part;

  assign adv = !out_valid_q || out_ready_i;

  // Fields of the record line being sent.
  always_comb begin
    len_v  = '0;
    addr_v = '0;
    type_v = TypeData;
    data_v = 8'h00;
    case (part_q)
      PART_SEG: begin
        len_v  = LenW'(2);
        type_v = TypeSeg;
        data_v = (idx_q == IdxW'(4)) ? head_i.seg_payload[15:8] : head_i.seg_payload[7:0];
      end
      PART_REC: begin
        len_v  = head_i.rec_len;
        addr_v = head_i.rec_start;
        data_v = rd_q;
      end
      PART_CK: begin
        len_v  = LenW'(1);
        addr_v = head_i.ck_addr;
        data_v = head_i.ck_byte;
      end
      default: type_v = TypeEnd;
    endcase
    last_idx = IdxW'(len_v) + IdxW'(4);
    if (idx_q == IdxW'(0)) begin
      cur_byte = 8'(len_v);
    end else if (idx_q == IdxW'(1)) begin
      cur_byte = addr_v[15:8];
    end else if (idx_q == IdxW'(2)) begin
      cur_byte = addr_v[7:0];
    end else if (idx_q == IdxW'(3)) begin
      cur_byte = type_v;
    end else if (idx_q == last_idx) begin
      cur_byte = ~sum_q + 8'd1;
    end else begin
      cur_byte = data_v;
    end
  end

  // Order of record lines within one descriptor.
  always_comb begin
    has_next  = 1'b0;
    next_part = PART_END;
    case (part_q)
      PART_SEG: begin
        if (head_i.rec) begin
          has_next  = 1'b1;
          next_part = PART_REC;
        end else if (head_i.seal) begin
          has_next  = 1'b1;
          next_part = PART_CK;
        end
      end
      PART_CK: begin
        has_next  = 1'b1;
        next_part = PART_END;
      end
      default: ;
    endcase
    if (head_i.seg) begin
      start_part = PART_SEG;
    end else if (head_i.rec) begin
      start_part = PART_REC;
    end else begin
      start_part = PART_CK;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (head_valid_i) state_d = BK_COLON;
      BK_COLON: if (adv) state_d = BK_HI;
      BK_HI:    if (adv) state_d = BK_LO;
      BK_LO:    if (adv) state_d = (idx_q == last_idx) ? BK_NL : BK_HI;
      BK_NL:    if (adv) state_d = has_next ? BK_COLON : BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Sequencer datapath and queue control.
  always_comb begin
    part_d     = part_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    pop_o      = 1'b0;
    bank_rel_o = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          part_d = start_part;
          idx_d  = '0;
          sum_d  = '0;
        end
      end
      BK_LO: begin
        if (adv) begin
          sum_d = sum_q + cur_byte;
          if (idx_q != last_idx) begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      BK_NL: begin
        if (adv) begin
          if (has_next) begin
            part_d = next_part;
            idx_d  = '0;
            sum_d  = '0;
          end else begin
            pop_o = 1'b1;
            if (part_q == PART_REC) begin
              bank_rel_o.en   = 1'b1;
              bank_rel_o.bank = head_i.rec_bank;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    if (adv) begin
      out_valid_d = (state_q != BK_IDLE);
      last_d      = (state_q == BK_NL) && !has_next;
      ovf_d       = (part_q == PART_SEG) ? head_i.ovf_hdr : head_i.ovf_body;
      unique case (state_q)
        BK_COLON: char_d = CharColon;
        BK_HI:    char_d = hex_char(cur_byte[7:4]);
        BK_LO:    char_d = hex_char(cur_byte[3:0]);
        BK_NL:    char_d = CharNl;
        default:  char_d = char_q;
      endcase
    end
  end

  // Read ahead on the next byte index so the data is registered when needed.
  always_comb begin
    data_idx = idx_d - IdxW'(4);
    if ((idx_d >= IdxW'(4)) && (data_idx < IdxW'(RecCap))) begin
      rd_slot = SlotW'(data_idx);
    end else begin
      rd_slot = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      mem_q[buf_wr_i.bank][buf_wr_i.slot[SlotW-1:0]] <= buf_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[head_i.rec_bank][rd_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      part_q      <= PART_SEG;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      part_q      <= part_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ascii_char_o    = char_q;
  assign last_of_run_o   = last_q;
  assign overflow_flag_o = ovf_q;

endmodule

### hw/rtl/rom_image_intel_hex_encoder_unit.sv
// Top level of the ROM image Intel HEX encoder: configuration registers,
// front end, descriptor queue and back end. Depends on rihe_pkg and rihe_ifs.
//
// Feed image bytes (opcode 0) at sequential addresses from 0; the block answers
// with Intel HEX text, one character per output transaction, and marks the last
// character of each input transaction. The first transaction after reset or seal
// is preceded by a type-02 segment record from load_base[19:4]. Bytes collect into
// data records of RECORD_BYTES (clamped to 1..24); flush (opcode 1) sends a partial
// record, seal (opcode 2) sends the checksum byte record at checksum_address and the
// end record, or only flushes when a partial record is pending. Records starting
// below kill_below are dropped silently. Rate: the front end takes one input
// transaction per cycle while the two-entry descriptor queue has room and the
// record bank it fills is free; the back end sends one character per cycle while
// the receiver is ready, and loads each descriptor in its idle state. A record
// of n bytes is 12+2n characters. No clearing pass after reset.
// Write configuration only while the block is idle.
module rom_image_intel_hex_encoder_unit import rihe_pkg::*; #(
  parameter int unsigned RECORD_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rihe_in_if.sink    in_i,
  rihe_out_if.source out_o,
  rihe_cfg_if.sink   cfg_i
);

  // Clamp the record length so one transaction never exceeds 60 characters.
  localparam int unsigned RecCap = (RECORD_BYTES < 1) ? 1 :
                                   ((RECORD_BYTES > RecCapMax) ? RecCapMax : RECORD_BYTES);

  cfg_t      cfg_q, cfg_d;
  logic      fifo_full;
  logic      fifo_valid;
  logic      push;
  logic      pop;
  desc_t     push_desc;
  desc_t     head;
  buf_wr_t   buf_wr;
  bank_rel_t bank_rel;
  logic      in_ready;

  // Configuration writes are always accepted.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_LOAD_BASE:  cfg_d.load_base  = cfg_i.data;
        REG_KILL_BELOW: cfg_d.kill_below = cfg_i.data[15:0];
        REG_LOAD_LIMIT: cfg_d.load_limit = cfg_i.data[16:0];
        REG_CKSUM_ADDR: cfg_d.cksum_addr = cfg_i.data[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_base  <= '0;
      cfg_q.kill_below <= '0;
      cfg_q.load_limit <= AddrTop;
      cfg_q.cksum_addr <= 16'hFFFE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classify items and stage record bytes.
  rihe_front #(
    .RecCap (RecCap)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .opcode_i    (in_i.opcode),
    .data_byte_i (in_i.data_byte),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .buf_wr_o    (buf_wr),
    .bank_rel_i  (bank_rel)
  );

  assign in_i.ready = in_ready;

  // Decouple the two sides so each can stall on its own.
  rihe_desc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .head_o      (head)
  );

  // Expand descriptors into characters.
  rihe_back #(
    .RecCap (RecCap)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (fifo_valid),
    .pop_o           (pop),
    .buf_wr_i        (buf_wr),
    .bank_rel_o      (bank_rel),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .ascii_char_o    (out_o.ascii_char),
    .last_of_run_o   (out_o.last_of_run),
    .overflow_flag_o (out_o.overflow_flag)
  );

endmodule

### hw/rtl/rihe_checker.sv
// Port-level checks on the character stream of the HEX encoder, bound to the
// top level. Depends on rom_image_intel_hex_encoder_unit.
module rihe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] ascii_char_i,
  input logic       last_of_run_i,
  input logic       overflow_flag_i
);

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ascii_char_i) &&
    $stable(last_of_run_i) && $stable(overflow_flag_i))
    else $error("output changed while stalled");

  // Only colon, uppercase hex digits and newline leave the block.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ascii_char_i == 8'h3A) || (ascii_char_i == 8'h0A) ||
    ((ascii_char_i >= 8'h30) && (ascii_char_i <= 8'h39)) ||
    ((ascii_char_i >= 8'h41) && (ascii_char_i <= 8'h46)))
    else $error("illegal character");

  // Every transaction ends at the end of a record line.
  a_last_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_run_i |-> ascii_char_i == 8'h0A)
    else $error("last character is not a newline");

  // A record start is never directly followed by another one.
  a_colon_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (ascii_char_i == 8'h3A) |=>
    !(out_valid_i && (ascii_char_i == 8'h3A)))
    else $error("empty record start");

endmodule

bind rom_image_intel_hex_encoder_unit rihe_checker u_rihe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .ascii_char_i    (out_o.ascii_char),
  .last_of_run_i   (out_o.last_of_run),
  .overflow_flag_i (out_o.overflow_flag)
);

### tb/rihe_hex_text_check.sv
// Self-checking watcher for the ROM image Intel HEX encoder: follows the input,
// output and configuration channels, predicts the text and compares it.
// Depends on rihe_pkg and the channel interfaces in rihe_ifs.
module rihe_hex_text_check import rihe_pkg::*; #(
  parameter int unsigned RECORD_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rihe_in_if          in_i,
  rihe_out_if         out_i,
  rihe_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned chars_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RecCap =
    (RECORD_BYTES < 1) ? 1 : ((RECORD_BYTES > RecCapMax) ? RecCapMax : RECORD_BYTES);
  localparam int unsigned ReportCap = 100;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } text_char_t;

  // Register copy.
  logic [19:0] load_base;
  logic [15:0] kill_below;
  logic [16:0] load_limit;
  logic [15:0] cksum_addr;

  // Encoder state copy.
  logic [7:0]  rec_buf [RecCapMax];
  int unsigned rec_fill;
  logic [15:0] rec_start;
  logic [16:0] next_addr;
  logic [7:0]  image_sum;
  logic        hdr_sent;
  logic        ovf_seen;

  text_char_t  text_q[$];

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    // uppercase digits: '0' is 48, 'A' is 55 + 10
    if (n < 4'd10) return 8'd48 + 8'(n);
    return 8'd55 + 8'(n);
  endfunction

  function automatic void emit_char(logic [7:0] c);
    text_q.push_back('{ch: c, last: 1'b0, ovf: ovf_seen});
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    emit_char(nibble_char(v[7:4]));
    emit_char(nibble_char(v[3:0]));
  endfunction

  function automatic void emit_record(logic [15:0] addr, logic [7:0] rtype,
                                      logic [7:0] payload[$]);
    logic [7:0] sum;
    sum = 8'(payload.size()) + rtype + addr[15:8] + addr[7:0];
    emit_char(CharColon);
    emit_byte(8'(payload.size()));
    emit_byte(addr[15:8]);
    emit_byte(addr[7:0]);
    emit_byte(rtype);
    foreach (payload[i]) begin
      emit_byte(payload[i]);
      sum += payload[i];
    end
    emit_byte(8'd0 - sum);
    emit_char(CharNl);
  endfunction

  // Send the pending record unless it starts below kill_below; drop it either way.
  function automatic void close_pending();
    logic [7:0] payload[$];
    if (rec_fill == 0) return;
    if (rec_start >= kill_below) begin
      for (int i = 0; i < rec_fill; i++) payload.push_back(rec_buf[i]);
      emit_record(rec_start, TypeData, payload);
    end
    rec_fill = 0;
  endfunction

  function automatic void predict_item(opcode_e op, logic [7:0] b);
    int unsigned first;
    logic [7:0]  payload[$];
    first = text_q.size();
    if (op == OP_NONE) return;
    if (!hdr_sent) begin
      payload = '{load_base[19:12], load_base[11:4]};
      emit_record(16'h0000, TypeSeg, payload);
      hdr_sent = 1'b1;
    end
    case (op)
      OP_DATA: begin
        if (next_addr >= AddrTop) begin
          // address space exhausted: stay saturated, flag it, flush what is pending
          ovf_seen = 1'b1;
          close_pending();
        end else if (next_addr > load_limit) begin
          close_pending();
          next_addr++;
        end else begin
          if (rec_fill == 0) rec_start = next_addr[15:0];
          rec_buf[rec_fill] = b;
          rec_fill++;
          image_sum += b;
          next_addr++;
          if (rec_fill >= RecCap) close_pending();
        end
      end
      OP_FLUSH: close_pending();
      default: begin
        if (rec_fill != 0) begin
          close_pending();
        end else begin
          payload = '{8'd0 - image_sum};
          emit_record(cksum_addr, TypeData, payload);
          payload.delete();
          emit_record(16'h0000, TypeEnd, payload);
          next_addr = '0;
          image_sum = '0;
          rec_start = '0;
          hdr_sent  = 1'b0;
          ovf_seen  = 1'b0;
        end
      end
    endcase
    if (text_q.size() > first) text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (mismatch_count_o < ReportCap) $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      load_base        = '0;
      kill_below       = '0;
      load_limit       = 17'h10000;
      cksum_addr       = 16'hFFFE;
      rec_fill         = 0;
      rec_start        = '0;
      next_addr        = '0;
      image_sum        = '0;
      hdr_sent         = 1'b0;
      ovf_seen         = 1'b0;
      text_q.delete();
      mismatch_count_o = 0;
      chars_owed_o     = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_LOAD_BASE:  load_base  = cfg_i.data[19:0];
          REG_KILL_BELOW: kill_below = cfg_i.data[15:0];
          REG_LOAD_LIMIT: load_limit = cfg_i.data[16:0];
          REG_CKSUM_ADDR: cksum_addr = cfg_i.data[15:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) predict_item(opcode_e'(in_i.opcode), in_i.data_byte);
      if (out_i.valid && out_i.ready) begin
        if (text_q.size() == 0) begin
          if (mismatch_count_o < ReportCap)
            $error("ascii_char: expected none, got %0h", out_i.ascii_char);
          mismatch_count_o++;
        end else begin
          want = text_q.pop_front();
          field_check("ascii_char", want.ch, out_i.ascii_char);
          field_check("last_of_run", 8'(want.last), 8'(out_i.last_of_run));
          field_check("overflow_flag", 8'(want.ovf), 8'(out_i.overflow_flag));
        end
      end
      chars_owed_o = text_q.size();
    end
  end

endmodule

### tb/rom_image_intel_hex_encoder_unit_tb.sv
// Testbench top of the ROM image Intel HEX encoder: clock, reset, stimulus and verdict.
// Depends on rihe_pkg, rihe_ifs, the encoder RTL and rihe_hex_text_check.
module rom_image_intel_hex_encoder_unit_tb import rihe_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RecordBytes = 16;
  // Quiet cycles after the last expected character before touching registers;
  // lets the back end return to idle.
  localparam int unsigned SettleCycles = 24;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned chars_owed;

  rihe_in_if  feed_if ();
  rihe_out_if text_if ();
  rihe_cfg_if cfg_if ();

  rom_image_intel_hex_encoder_unit #(
    .RECORD_BYTES(RecordBytes)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (feed_if),
    .out_o (text_if),
    .cfg_i (cfg_if)
  );

  rihe_hex_text_check #(
    .RECORD_BYTES(RecordBytes)
  ) text_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_i            (feed_if),
    .out_i           (text_if),
    .cfg_i           (cfg_if),
    .mismatch_count_o(mismatches),
    .chars_owed_o    (chars_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: some 470 transactions of at most 60 characters each, so the limit
  // leaves room even with every channel stalling.
  initial begin
    #5ms;
    $display("rom_image_intel_hex_encoder_unit verification failed");
    $finish;
  end

  // Receiver: drop ready at random, at the rate the current phase asks.
  initial begin
    text_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      text_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Send one input transaction. Called and returning at a falling edge; valid
  // stays high on return so that back-to-back transactions need no gap.
  task automatic push_item(opcode_e op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      feed_if.valid     <= 1'b0;
      feed_if.data_byte <= 8'($urandom);
      @(negedge clk);
    end
    feed_if.valid     <= 1'b1;
    feed_if.opcode    <= op;
    feed_if.data_byte <= b;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted character, then let the pipe drain.
  task automatic settle();
    feed_if.valid <= 1'b0;
    while (chars_owed != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all four registers back to back; only call while the encoder is idle.
  task automatic write_config(logic [19:0] base, logic [15:0] kill,
                              logic [16:0] limit, logic [15:0] ck);
    write_reg(REG_LOAD_BASE, base);
    write_reg(REG_KILL_BELOW, CfgDataW'(kill));
    write_reg(REG_LOAD_LIMIT, CfgDataW'(limit));
    write_reg(REG_CKSUM_ADDR, CfgDataW'(ck));
    cfg_if.valid <= 1'b0;
  endtask

  // Pick a setting, leaning on values that still let records out, with the
  // extremes of every register mixed in.
  task automatic random_config();
    logic [19:0] base;
    logic [15:0] kill;
    logic [16:0] limit;
    logic [15:0] ck;
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = 20'hFFFFF;
      default: base = 20'($urandom);
    endcase
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: kill = '0;
      12, 13, 14, 15, 16:                   kill = 16'($urandom_range(256));
      17, 18:                               kill = 16'($urandom);
      default:                              kill = 16'hFFFF;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: limit = 17'h10000;
      6, 7:             limit = 17'($urandom_range(300));
      8:                limit = '0;
      default:          limit = 17'($urandom_range(17'h10000));
    endcase
    case ($urandom_range(3))
      0:       ck = '0;
      1:       ck = 16'hFFFF;
      default: ck = 16'($urandom);
    endcase
    write_config(base, kill, limit, ck);
  endtask

  // Mostly runs of image bytes broken up by flushes and seals, with a little
  // noise from the unused opcode. Seal goes out twice so that a pending record
  // flushes first and the image is closed on the second.
  task automatic random_run(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        burst = $urandom_range(40, 1);
        repeat (burst) push_item(OP_DATA, 8'($urandom));
        sent += burst;
      end else if (pick < 82) begin
        push_item(OP_FLUSH, 8'($urandom));
        sent++;
      end else if (pick < 95) begin
        push_item(OP_SEAL, 8'($urandom));
        push_item(OP_SEAL, 8'($urandom));
        sent += 2;
      end else begin
        push_item(OP_NONE, 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned mode;
    // Known values on every input before the first edge.
    rst_n             = 1'b0;
    feed_if.valid     = 1'b0;
    feed_if.opcode    = OP_DATA;
    feed_if.data_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_LOAD_BASE;
    cfg_if.data       = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full-scale segment base, checksum at the top address. The first
    // transaction carries the segment record; a flush with nothing pending sends
    // nothing; the unused opcode is ignored, even right after a seal; a seal with
    // a partial record only flushes, the second one closes the image.
    write_config(20'hFFFFF, 16'h0000, 17'h10000, 16'hFFFF);
    push_item(OP_DATA, 8'h00);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'hA5);
    push_item(OP_DATA, 8'h5A);
    push_item(OP_FLUSH, 8'h00);
    push_item(OP_FLUSH, 8'hFF);
    push_item(OP_NONE, 8'h00);
    push_item(OP_DATA, 8'h3C);
    push_item(OP_DATA, 8'hC3);
    push_item(OP_SEAL, 8'h00);
    push_item(OP_SEAL, 8'h00);
    push_item(OP_NONE, 8'hFF);
    push_item(OP_FLUSH, 8'h00);
    push_item(OP_DATA, 8'h7E);
    push_item(OP_SEAL, 8'h00);
    push_item(OP_SEAL, 8'h00);

    // Directed: load limit at 5 and kill_below at 8. The byte past the limit
    // closes the pending record, which starts too low and is suppressed; the
    // seal still reports the sum of the bytes that were kept.
    settle();
    write_config(20'h00000, 16'h0008, 17'h00005, 16'h0000);
    repeat (8) push_item(OP_DATA, 8'($urandom));
    push_item(OP_SEAL, 8'h00);

    // Random phases, cycling through the idle/stall mixes.
    for (int p = 0; p < 8; p++) begin
      settle();
      random_config();
      mode = p % 4;
      case (mode)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 53;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 53;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct     = 30;
        end
      endcase
      random_run(45);
    end

    settle();
    if (mismatches == 0) begin
      $display("rom_image_intel_hex_encoder_unit verification clean");
    end else begin
      $display("rom_image_intel_hex_encoder_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rihe_pkg.sv
hw/rtl/rihe_ifs.sv
hw/rtl/rihe_desc_fifo.sv
hw/rtl/rihe_front.sv
hw/rtl/rihe_back.sv
hw/rtl/rom_image_intel_hex_encoder_unit.sv
hw/rtl/rihe_checker.sv
tb/rihe_hex_text_check.sv
tb/rom_image_intel_hex_encoder_unit_tb.sv
